/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/zpc_pkg.sv */
// Types, constants and helpers of the ZMP preview controller.
package zpc_pkg;

    localparam int PREVIEW_LEN = 256;
    localparam int WIN_AW      = $clog2(PREVIEW_LEN);
    localparam int CNT_W       = WIN_AW + 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_KI   = 3'd0;
    localparam logic [2:0] CFG_KPOS = 3'd1;
    localparam logic [2:0] CFG_KVEL = 3'd2;
    localparam logic [2:0] CFG_KACC = 3'd3;
    localparam logic [2:0] CFG_T    = 3'd4;
    localparam logic [2:0] CFG_HSQ  = 3'd5;
    localparam logic [2:0] CFG_SCB  = 3'd6;
    localparam logic [2:0] CFG_HOG  = 3'd7;

    typedef struct packed {
        logic               op;
        logic [7:0]         gain_index;
        logic signed [47:0] gain_value;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] com_x;
        logic signed [31:0] com_y;
        logic signed [31:0] zmp_x;
        logic signed [31:0] zmp_y;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic first;
        logic sub;
        logic sh32;
    } t_mac_ctl;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] == v[31]) begin
            r = v[31:0];
        end else if (v[32]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

/* sv/zpc_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation to Q16.16.
module zpc_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  zpc_pkg::t_mac_ctl   i_ctl,
    input  logic signed [32:0]  i_op_a,
    input  logic signed [32:0]  i_op_b,
    input  logic                i_rnd24,
    output logic signed [31:0]  o_rnd
);
    import zpc_pkg::*;

    t_mac_ctl           r_ctl;
    logic signed [65:0] r_prod;
    logic signed [95:0] r_acc;
    logic signed [95:0] n_acc;
    logic signed [95:0] prod_ext;
    logic signed [95:0] term;
    logic signed [95:0] base;
    logic signed [95:0] rsum;
    logic signed [71:0] shifted;
    logic               in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_prod <= i_op_a * i_op_b;
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        prod_ext = {{30{r_prod[65]}}, r_prod};
        term     = r_ctl.sh32 ? (prod_ext <<< 32) : prod_ext;
        base     = r_ctl.first ? '0 : r_acc;
        n_acc    = r_ctl.sub ? (base - term) : (base + term);
    end

    always_comb begin
        rsum     = r_acc + (i_rnd24 ? (96'sd1 <<< 23) : (96'sd1 <<< 31));
        shifted  = i_rnd24 ? rsum[95:24] : {{8{rsum[95]}}, rsum[95:32]};
        in_range = (&shifted[71:31]) | ~(|shifted[71:31]);
        if (in_range) begin
            o_rnd = shifted[31:0];
        end else if (shifted[71]) begin
            o_rnd = 32'sh8000_0000;
        end else begin
            o_rnd = 32'sh7FFF_FFFF;
        end
    end

endmodule

/* sv/zmp_preview_controller.sv */
// ZMP preview controller top level: sequencer, gain table, reference window, cart state.
// Loads, and samples that do not fill the window, do not stall the input. A sample that
// fills it runs a control step that stalls the input (x axis, then y axis, then output),
// and its result is then presented at the output. The step runs on the single shared
// multiply-accumulate unit, which handles one 32-bit slice of one product per cycle
// while it issues (48-bit gains take two passes).
// The input stalls while a step runs or while a finished result waits for the output.
module zmp_preview_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  zpc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output zpc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data
);
    import zpc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [2:0] PH_ZMP = 3'd0;
    localparam logic [2:0] PH_FB  = 3'd1;
    localparam logic [2:0] PH_TAP = 3'd2;
    localparam logic [2:0] PH_POS = 3'd3;
    localparam logic [2:0] PH_VEL = 3'd4;
    localparam logic [2:0] PH_ACC = 3'd5;

    localparam logic [CNT_W-1:0] TAP_LAST = CNT_W'(2 * PREVIEW_LEN - 1);

    // configuration
    logic signed [47:0] r_ki, r_kpos, r_kvel, r_kacc;
    logic [31:0]        r_t, r_hsq, r_scb, r_hog;

    // control
    logic [1:0]        r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_dcnt, n_dcnt;
    logic              r_axis, n_axis;
    logic [WIN_AW-1:0] r_head, n_head;
    logic [WIN_AW-1:0] r_fill, n_fill;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic signed [31:0] r_cart [2][3];
    logic signed [31:0] r_esum [2];
    logic signed [31:0] r_zmp  [2];
    logic signed [31:0] r_err;
    logic signed [31:0] r_u;
    t_out_item          r_out;

    // memories
    logic [47:0] r_gmem [PREVIEW_LEN];
    logic [63:0] r_wmem [PREVIEW_LEN];
    logic [47:0] r_gain_q;
    logic [63:0] r_win_q;

    logic              in_acc;
    logic              last_op;
    logic              commit;
    logic              win_full;
    logic [WIN_AW-1:0] tap_idx;
    logic [WIN_AW-1:0] win_raddr;
    logic [WIN_AW-1:0] win_waddr;

    logic signed [31:0] cp, cv, ca, ce, cw;
    logic signed [47:0] kg;
    logic signed [31:0] kb;
    logic signed [47:0] gsel;
    logic signed [32:0] op_a, op_b;
    t_mac_ctl           mac_ctl;
    logic signed [31:0] rnd;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign commit      = (r_state == ST_DRAIN) && r_dcnt;
    assign win_full    = (r_fill == WIN_AW'(PREVIEW_LEN - 1));

    assign tap_idx   = n_cnt[WIN_AW:1];
    assign win_raddr = r_head + tap_idx;
    assign win_waddr = r_head + r_fill;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ki   <= '0;
            r_kpos <= '0;
            r_kvel <= '0;
            r_kacc <= '0;
            r_t    <= 32'd21474836;
            r_hsq  <= 32'd53687;
            r_scb  <= 32'd89;
            r_hog  <= 32'd356745139;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KI:   r_ki   <= i_cfg_data;
                CFG_KPOS: r_kpos <= i_cfg_data;
                CFG_KVEL: r_kvel <= i_cfg_data;
                CFG_KACC: r_kacc <= i_cfg_data;
                CFG_T:    r_t    <= i_cfg_data[31:0];
                CFG_HSQ:  r_hsq  <= i_cfg_data[31:0];
                CFG_SCB:  r_scb  <= i_cfg_data[31:0];
                CFG_HOG:  r_hog  <= i_cfg_data[31:0];
                default:  r_ki   <= r_ki;
            endcase
        end
    end

    // gain table
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.op == OP_LOAD)) begin
            r_gmem[i_in_data.gain_index[WIN_AW-1:0]] <= i_in_data.gain_value;
        end
        r_gain_q <= r_gmem[tap_idx];
    end

    // reference window, {x, y} per entry
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.op == OP_SAMPLE)) begin
            r_wmem[win_waddr] <= {i_in_data.ref_x, i_in_data.ref_y};
        end
        r_win_q <= r_wmem[win_raddr];
    end

    // operand selection
    always_comb begin
        cp   = r_cart[r_axis][0];
        cv   = r_cart[r_axis][1];
        ca   = r_cart[r_axis][2];
        ce   = r_esum[r_axis];
        cw   = r_axis ? r_win_q[31:0] : r_win_q[63:32];
        gsel = r_gain_q;
        case (r_cnt[2:1])
            2'd0:    begin kg = r_ki;   kb = ce; end
            2'd1:    begin kg = r_kpos; kb = cp; end
            2'd2:    begin kg = r_kvel; kb = cv; end
            default: begin kg = r_kacc; kb = ca; end
        endcase
        op_a          = 33'sd1;
        op_b          = {cp[31], cp};
        mac_ctl.valid = (r_state == ST_ISSUE);
        mac_ctl.first = (r_cnt == '0);
        mac_ctl.sub   = 1'b0;
        mac_ctl.sh32  = 1'b1;
        last_op       = 1'b0;
        case (r_phase)
            PH_ZMP: begin
                last_op = (r_cnt == CNT_W'(1));
                if (r_cnt[0]) begin
                    op_a         = {1'b0, r_hog};
                    op_b         = {ca[31], ca};
                    mac_ctl.sub  = 1'b1;
                    mac_ctl.sh32 = 1'b0;
                end
            end
            PH_FB: begin
                last_op      = (r_cnt == CNT_W'(7));
                op_a         = r_cnt[0] ? {{17{kg[47]}}, kg[47:32]} : {1'b0, kg[31:0]};
                op_b         = {kb[31], kb};
                mac_ctl.sub  = 1'b1;
                mac_ctl.sh32 = r_cnt[0];
            end
            PH_TAP: begin
                last_op       = (r_cnt == TAP_LAST);
                op_a          = r_cnt[0] ? {{17{gsel[47]}}, gsel[47:32]}
                                         : {1'b0, gsel[31:0]};
                op_b          = {cw[31], cw};
                mac_ctl.sub   = 1'b1;
                mac_ctl.sh32  = r_cnt[0];
                mac_ctl.first = 1'b0;
            end
            PH_POS: begin
                last_op = (r_cnt == CNT_W'(3));
                case (r_cnt[1:0])
                    2'd0:    op_b = {cp[31], cp};
                    2'd1:    begin op_a = {1'b0, r_t};   op_b = {cv[31], cv};   end
                    2'd2:    begin op_a = {1'b0, r_hsq}; op_b = {ca[31], ca};   end
                    default: begin op_a = {1'b0, r_scb}; op_b = {r_u[31], r_u}; end
                endcase
                mac_ctl.sh32 = (r_cnt == '0);
            end
            PH_VEL: begin
                last_op = (r_cnt == CNT_W'(2));
                case (r_cnt[1:0])
                    2'd0:    op_b = {cv[31], cv};
                    2'd1:    begin op_a = {1'b0, r_t};   op_b = {ca[31], ca};   end
                    default: begin op_a = {1'b0, r_hsq}; op_b = {r_u[31], r_u}; end
                endcase
                mac_ctl.sh32 = (r_cnt == '0);
            end
            default: begin
                last_op = (r_cnt == CNT_W'(1));
                if (r_cnt[0]) begin
                    op_a = {1'b0, r_t};
                    op_b = {r_u[31], r_u};
                end else begin
                    op_b = {ca[31], ca};
                end
                mac_ctl.sh32 = (r_cnt == '0);
            end
        endcase
    end

    zpc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .i_rnd24 (r_phase == PH_TAP),
        .o_rnd   (rnd)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_dcnt      = r_dcnt;
        n_axis      = r_axis;
        n_head      = r_head;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.op == OP_SAMPLE)) begin
                    if (win_full) begin
                        n_state = ST_ISSUE;
                        n_phase = PH_ZMP;
                        n_axis  = 1'b0;
                        n_cnt   = '0;
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            ST_ISSUE: begin
                if (last_op) begin
                    n_cnt = '0;
                    if (r_phase == PH_FB) begin
                        n_phase = PH_TAP;
                    end else begin
                        n_state = ST_DRAIN;
                        n_dcnt  = 1'b0;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_dcnt = 1'b1;
                if (r_dcnt) begin
                    n_state = ST_ISSUE;
                    case (r_phase)
                        PH_ZMP: n_phase = PH_FB;
                        PH_TAP: n_phase = PH_POS;
                        PH_POS: n_phase = PH_VEL;
                        PH_VEL: n_phase = PH_ACC;
                        default: begin
                            if (r_axis) begin
                                n_state = ST_OUT;
                            end else begin
                                n_axis  = 1'b1;
                                n_phase = PH_ZMP;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_head      = r_head + 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_ZMP;
            r_cnt       <= '0;
            r_dcnt      <= 1'b0;
            r_axis      <= 1'b0;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cart      <= '{default: '0};
            r_esum      <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_dcnt      <= n_dcnt;
            r_axis      <= n_axis;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (commit) begin
                case (r_phase)
                    PH_TAP: r_esum[r_axis]    <= sat33({ce[31], ce} + {r_err[31], r_err});
                    PH_POS: r_cart[r_axis][0] <= rnd;
                    PH_VEL: r_cart[r_axis][1] <= rnd;
                    PH_ACC: r_cart[r_axis][2] <= rnd;
                    default: r_esum[r_axis]   <= ce;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && (r_phase == PH_ZMP)) begin
            r_zmp[r_axis] <= rnd;
            r_err         <= sat33({rnd[31], rnd} - {cw[31], cw});
        end
        if (commit && (r_phase == PH_TAP)) begin
            r_u <= rnd;
        end
        if ((r_state == ST_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_out.com_x <= r_cart[0][0];
            r_out.com_y <= r_cart[1][0];
            r_out.zmp_x <= r_zmp[0];
            r_out.zmp_y <= r_zmp[1];
        end
    end

    `include "assert_macros.svh"

    `ASSERT_IMP(a_out_from_seq, $rose(o_out_valid), $past(r_state) == ST_OUT)
    `ASSERT_NXT(a_short_sample, in_acc && (i_in_data.op == OP_SAMPLE) && !win_full, r_state == ST_IDLE)
    `ASSERT_IMP(a_out_after_y, r_state == ST_OUT, r_axis && win_full)

endmodule
